>>> hw/rtl/tcgl_pkg.sv
// Shared types and constants for the text cursor glyph layout unit.
package tcgl_pkg;

	localparam int unsigned CoordW    = 12;
	localparam int unsigned AddrW     = 21;
	localparam int unsigned ColorW    = 24;
	localparam int unsigned CmdDepth  = 4;
	localparam int unsigned ResDepth  = 2;

	localparam logic [CoordW-1:0] CoordMax     = 12'd4095;
	localparam logic [CoordW-1:0] LineStep     = 12'd16;
	localparam logic [CoordW-1:0] AsciiAdvance = 12'd8;
	localparam logic [CoordW-1:0] GbkAdvance   = 12'd16;
	localparam logic [CoordW-1:0] WidthReset   = 12'd480;
	localparam logic [CoordW-1:0] HeightReset  = 12'd272;
	localparam logic [CoordW:0]   BottomMargin = 13'd10;
	localparam logic [AddrW-1:0]  GbkBase      = 21'h100000;
	localparam logic [7:0]        GbkLeadBase  = 8'h81;
	localparam logic [7:0]        GbkPerRow    = 8'd190;

	localparam logic [7:0] ByteNul      = 8'h00;
	localparam logic [7:0] ByteLf       = 8'h0a;
	localparam logic [7:0] ByteCr       = 8'h0d;
	localparam logic [7:0] ByteDel      = 8'h7f;
	localparam logic [7:0] ByteHiBase   = 8'h80;
	localparam logic [7:0] TrailLow     = 8'h40;
	localparam logic [7:0] TrailHigh    = 8'hfe;
	localparam logic [7:0] TrailHiShift = 8'h41;

	// APB register map
	localparam int unsigned PaddrW   = 3;
	localparam logic        RegWidth  = 1'b0;
	localparam logic        RegHeight = 1'b1;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_LF    = 3'd1,
		OP_CR    = 3'd2,
		OP_ASCII = 3'd3,
		OP_GBK   = 3'd4
	} op_t;

	typedef struct packed {
		logic [7:0]        text_byte;
		logic              first_of_string;
		logic [CoordW-1:0] start_x;
		logic [CoordW-1:0] start_y;
		logic [ColorW-1:0] ink_color;
	} item_t;

	typedef struct packed {
		logic              glyph_kind;
		logic [CoordW-1:0] glyph_x;
		logic [CoordW-1:0] glyph_y;
		logic [AddrW-1:0]  font_address;
		logic [ColorW-1:0] glyph_color;
	} result_t;

	// One command from the classifier to the cursor engine
	typedef struct packed {
		logic              load;
		logic [CoordW-1:0] start_x;
		logic [CoordW-1:0] start_y;
		op_t               op;
		logic [AddrW-1:0]  font_address;
		logic [ColorW-1:0] color;
	} cmd_t;

	function automatic logic [CoordW-1:0] sat_add(logic [CoordW-1:0] a, logic [CoordW-1:0] b);
		logic [CoordW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, CoordMax}) ? CoordMax : s[CoordW-1:0];
	endfunction

endpackage

>>> hw/rtl/text_cursor_glyph_layout_unit.sv
// Text cursor glyph layout unit: top level with APB registers and queues.
// Throughput: one byte per cycle while full is low; each byte is classified on entry
// and the cursor engine retires one command per cycle from a CMD_DEPTH-entry queue,
// held while a glyph meets a full result queue, which holds glyphs until popped.
// Reset: cursor, pending lead and suppression cleared, screen 480x272, queues empty.
module text_cursor_glyph_layout_unit import tcgl_pkg::*; #(
	parameter int unsigned CMD_DEPTH = CmdDepth,
	parameter int unsigned RES_DEPTH = ResDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  item_t             item,
	output logic              empty,
	input  logic              pop,
	output result_t           result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [PaddrW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [CoordW-1:0] width_q, height_q;
	logic              accept, cfg_wr;
	logic              cmd_valid, cmd_pop, cmd_empty;
	cmd_t              cmd_in, cmd_head;
	logic              res_push, res_full;
	result_t           res_in;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == RegHeight) ? {20'b0, height_q} : {20'b0, width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WidthReset;
			height_q <= HeightReset;
		end else if (cfg_wr) begin
			if (paddr[2] == RegWidth) begin
				width_q <= pwdata[CoordW-1:0];
			end else begin
				height_q <= pwdata[CoordW-1:0];
			end
		end
	end

	assign accept = push && !full;

	tcgl_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.item          (item),
		.screen_height (height_q),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd_in)
	);

	tcgl_fifo #(
		.DEPTH   (CMD_DEPTH),
		.entry_t (cmd_t)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_valid),
		.wr_data (cmd_in),
		.rd_en   (cmd_pop),
		.rd_data (cmd_head),
		.full    (full),
		.empty   (cmd_empty)
	);

	tcgl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_empty    (cmd_empty),
		.cmd          (cmd_head),
		.res_full     (res_full),
		.screen_width (width_q),
		.cmd_pop      (cmd_pop),
		.res_push     (res_push),
		.res          (res_in)
	);

	tcgl_fifo #(
		.DEPTH   (RES_DEPTH),
		.entry_t (result_t)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.rd_en   (pop),
		.rd_data (result),
		.full    (res_full),
		.empty   (empty)
	);

endmodule

>>> hw/rtl/tcgl_fifo.sv
// Small synchronous queue used between the classifier, the cursor engine and the result port.
module tcgl_fifo import tcgl_pkg::*; #(
	parameter int unsigned DEPTH = CmdDepth,
	parameter type entry_t = cmd_t
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  entry_t wr_data,
	input  logic   rd_en,
	output entry_t rd_data,
	output logic   full,
	output logic   empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

	entry_t        entries_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign full    = (count_q == FullCnt);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/tcgl_front.sv
// Byte classifier: string start, suppression, GBK pairing and font address.
module tcgl_front import tcgl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  item_t             item,
	input  logic [CoordW-1:0] screen_height,
	output logic              cmd_valid,
	output cmd_t              cmd
);

	logic       pending_q;
	logic [7:0] lead_q;
	logic       suppressed_q;

	logic       susp_new, susp_eff, pend_eff;
	logic       pend_n;
	logic [7:0] b;
	logic       trail_ok;
	logic [6:0] row;
	logic [7:0] col;
	logic [14:0] gbk_idx;
	op_t        op;

	assign b        = item.text_byte;
	assign susp_new = ({1'b0, item.start_y} + BottomMargin) > {1'b0, screen_height};
	assign susp_eff = item.first_of_string ? susp_new : suppressed_q;
	assign pend_eff = item.first_of_string ? 1'b0 : pending_q;
	assign trail_ok = (b >= TrailLow) && (b <= TrailHigh) && (b != ByteDel);
	// lead is always 0x81..0xFF, so the row fits in 7 bits
	assign row      = 7'(lead_q - GbkLeadBase);
	assign col      = (b > ByteDel) ? (b - TrailHiShift) : (b - TrailLow);
	// largest index is 126 * 190 + 189, inside 15 bits
	assign gbk_idx  = 15'(row) * 15'(GbkPerRow) + 15'(col);

	always_comb begin
		op     = OP_NONE;
		pend_n = pend_eff;
		if (!susp_eff) begin
			if (pend_eff) begin
				pend_n = 1'b0;
				if (trail_ok) begin
					op = OP_GBK;
				end
			end else if (b == ByteNul || b == ByteHiBase) begin
				op = OP_NONE;
			end else if (b > ByteHiBase) begin
				pend_n = 1'b1;
			end else if (b == ByteLf) begin
				op = OP_LF;
			end else if (b == ByteCr) begin
				op = OP_CR;
			end else begin
				op = OP_ASCII;
			end
		end
	end

	always_comb begin
		cmd.load         = item.first_of_string;
		cmd.start_x      = item.start_x;
		cmd.start_y      = item.start_y;
		cmd.op           = op;
		cmd.color        = item.ink_color;
		cmd.font_address = (op == OP_GBK) ? (GbkBase | {1'b0, gbk_idx, 5'b0})
		                                  : {9'b0, b, 4'b0};
	end

	assign cmd_valid = accept && (item.first_of_string || op != OP_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= 1'b0;
			lead_q       <= '0;
			suppressed_q <= 1'b0;
		end else if (accept) begin
			if (item.first_of_string) begin
				suppressed_q <= susp_new;
			end
			if (!susp_eff) begin
				pending_q <= pend_n;
				if (!pend_eff && b > ByteHiBase) begin
					lead_q <= b;
				end
			end else if (item.first_of_string) begin
				pending_q <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/tcgl_back.sv
// Cursor engine: wrap, newline, carriage return and glyph placement.
module tcgl_back import tcgl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_empty,
	input  cmd_t              cmd,
	input  logic              res_full,
	input  logic [CoordW-1:0] screen_width,
	output logic              cmd_pop,
	output logic              res_push,
	output result_t           res
);

	logic [CoordW-1:0] cx_q, cy_q;
	logic [CoordW-1:0] cx0, cy0, cx_n, cy_n, gx, gy, adv;
	logic              is_glyph, wrap;

	assign cx0      = cmd.load ? cmd.start_x : cx_q;
	assign cy0      = cmd.load ? cmd.start_y : cy_q;
	assign wrap     = cx0 > screen_width;
	assign gx       = wrap ? '0 : cx0;
	assign gy       = wrap ? sat_add(cy0, LineStep) : cy0;
	assign is_glyph = (cmd.op == OP_ASCII) || (cmd.op == OP_GBK);
	assign adv      = (cmd.op == OP_GBK) ? GbkAdvance : AsciiAdvance;

	assign cmd_pop  = !cmd_empty && (!is_glyph || !res_full);
	assign res_push = cmd_pop && is_glyph;

	always_comb begin
		cx_n = cx0;
		cy_n = cy0;
		unique case (cmd.op)
			OP_LF: begin
				cy_n = sat_add(cy0, LineStep);
			end
			OP_CR: begin
				cx_n = '0;
			end
			OP_ASCII, OP_GBK: begin
				cx_n = sat_add(gx, adv);
				cy_n = gy;
			end
			default: begin
				cx_n = cx0;
			end
		endcase
	end

	always_comb begin
		res.glyph_kind   = (cmd.op == OP_GBK);
		res.glyph_x      = gx;
		res.glyph_y      = gy;
		res.font_address = cmd.font_address;
		res.glyph_color  = cmd.color;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
		end else if (cmd_pop) begin
			cx_q <= cx_n;
			cy_q <= cy_n;
		end
	end

endmodule

>>> tb/tb_text_cursor_glyph_layout_unit.sv
// Self-checking testbench for the text cursor glyph layout unit.
`timescale 1ns / 100ps

module tb_text_cursor_glyph_layout_unit;
	import tcgl_pkg::*;

	localparam logic        GlyphAscii   = 1'b0;
	localparam logic        GlyphGbk     = 1'b1;
	localparam int unsigned AsciiStride  = 16;
	localparam int unsigned GbkStride    = 32;
	localparam int          PhaseCount   = 7;
	localparam int          PhaseItems   = 115;
	localparam int          LongHold     = 100;
	localparam int          SettleCycles = CmdDepth + ResDepth + 8;
	localparam int          StallLimit   = 2000;
	localparam int          MaxPrinted   = 100;

	// Predicts glyph commands from accepted requests and checks the results against them
	class glyph_scoreboard;
		logic [CoordW-1:0] width_reg, height_reg, cur_x, cur_y;
		logic              lead_held, muted;
		logic [7:0]        lead_code;
		result_t           glyph_q[$];
		int                errors, ascii_glyphs, gbk_glyphs;

		function new();
			width_reg  = WidthReset;
			height_reg = HeightReset;
			cur_x      = '0;
			cur_y      = '0;
			lead_held  = 1'b0;
			lead_code  = '0;
			muted      = 1'b0;
		endfunction

		function void set_register(logic idx, logic [CoordW-1:0] value);
			if (idx == RegWidth)
				width_reg = value;
			else
				height_reg = value;
		endfunction

		function logic [CoordW-1:0] clamp_add(logic [CoordW-1:0] a, logic [CoordW-1:0] b);
			logic [CoordW:0] s;
			s = a + b;
			return s[CoordW] ? CoordMax : s[CoordW-1:0];
		endfunction

		function void place_glyph(logic kind, logic [AddrW-1:0] addr,
			logic [ColorW-1:0] color, logic [CoordW-1:0] adv);
			result_t g;
			if (cur_x > width_reg) begin
				cur_x = '0;
				cur_y = clamp_add(cur_y, LineStep);
			end
			g.glyph_kind   = kind;
			g.glyph_x      = cur_x;
			g.glyph_y      = cur_y;
			g.font_address = addr;
			g.glyph_color  = color;
			glyph_q.push_back(g);
			cur_x = clamp_add(cur_x, adv);
		endfunction

		// Returns 0 when the request falls in a suppressed string.
		function bit note_request(item_t it);
			logic [7:0]  b;
			int unsigned row, col, addr;
			b = it.text_byte;
			if (it.first_of_string) begin
				cur_x     = it.start_x;
				cur_y     = it.start_y;
				lead_held = 1'b0;
				lead_code = '0;
				muted     = ({1'b0, it.start_y} + BottomMargin) > {1'b0, height_reg};
			end
			if (muted)
				return 1'b0;
			if (lead_held) begin
				// any byte after a lead is its trail, good or bad
				lead_held = 1'b0;
				if (b < TrailLow || b > TrailHigh || b == ByteDel)
					return 1'b1;
				row  = int'(lead_code) - int'(GbkLeadBase);
				col  = (b > ByteDel) ? int'(b) - int'(TrailHiShift) : int'(b) - int'(TrailLow);
				addr = int'(GbkBase) + (row * int'(GbkPerRow) + col) * GbkStride;
				place_glyph(GlyphGbk, addr[AddrW-1:0], it.ink_color, GbkAdvance);
				return 1'b1;
			end
			if (b == ByteNul || b == ByteHiBase)
				return 1'b1;
			if (b > ByteHiBase) begin
				lead_code = b;
				lead_held = 1'b1;
			end else if (b == ByteLf) begin
				cur_y = clamp_add(cur_y, LineStep);
			end else if (b == ByteCr) begin
				cur_x = '0;
			end else begin
				addr = int'(b) * AsciiStride;
				place_glyph(GlyphAscii, addr[AddrW-1:0], it.ink_color, AsciiAdvance);
			end
			return 1'b1;
		endfunction

		function int pending();
			return glyph_q.size();
		endfunction

		task report(string what);
			errors++;
			if (errors <= MaxPrinted)
				$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_glyph(result_t got);
			result_t want;
			if (glyph_q.size() == 0) begin
				report($sformatf("glyph with nothing expected: %p", got));
				return;
			end
			want = glyph_q.pop_front();
			if (want.glyph_kind == GlyphGbk)
				gbk_glyphs++;
			else
				ascii_glyphs++;
			if (got.glyph_kind !== want.glyph_kind)
				report($sformatf("glyph_kind %0d, want %0d", got.glyph_kind, want.glyph_kind));
			if (got.glyph_x !== want.glyph_x)
				report($sformatf("glyph_x %0d, want %0d", got.glyph_x, want.glyph_x));
			if (got.glyph_y !== want.glyph_y)
				report($sformatf("glyph_y %0d, want %0d", got.glyph_y, want.glyph_y));
			if (got.font_address !== want.font_address)
				report($sformatf("font_address %h, want %h", got.font_address, want.font_address));
			if (got.glyph_color !== want.glyph_color)
				report($sformatf("glyph_color %h, want %h", got.glyph_color, want.glyph_color));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              push, full, empty, pop;
	item_t             item;
	result_t           result;
	logic              psel, penable, pwrite, pready;
	logic [PaddrW-1:0] paddr;
	logic [31:0]       pwdata, prdata;

	glyph_scoreboard   sb = new();
	int                counted = 0;
	int                muted_reqs = 0;
	int                burst_left = 0;
	int                idle_cycles = 0;
	bit                rx_hold_req = 1'b0;
	logic              head_pending = 1'b0;
	logic [CoordW-1:0] head_x, head_y;

	text_cursor_glyph_layout_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Results are taken at the rising edge, checked in order
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_glyph(result);
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= StallLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: stall pattern steps through four modes in turn; a hold request blocks it for a while
	initial begin : result_sink
		int hold_left, tick;
		pop       = 1'b0;
		hold_left = 0;
		tick      = 0;
		forever begin
			@(negedge clk);
			tick++;
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold_left   = LongHold;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case ((tick / 150) % 4)
					0: pop <= 1'b1;
					1: pop <= ($urandom_range(0, 3) != 0);
					2: pop <= ((tick % 5) < 2);
					default: pop <= 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	task automatic start_string(input logic [CoordW-1:0] sx, input logic [CoordW-1:0] sy);
		head_pending = 1'b1;
		head_x       = sx;
		head_y       = sy;
	endtask

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic offer(input logic [7:0] b);
		item_t it;
		if (burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
				: $urandom_range(1, 12);
		end
		burst_left--;
		it.text_byte       = b;
		it.first_of_string = head_pending;
		it.start_x         = head_pending ? head_x : CoordW'($urandom);
		it.start_y         = head_pending ? head_y : CoordW'($urandom);
		it.ink_color       = ColorW'($urandom);
		head_pending       = 1'b0;
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		if (sb.note_request(it))
			counted++;
		else
			muted_reqs++;
		@(negedge clk);
	endtask

	// Stop sending and wait for every expected glyph, then let the command queue settle.
	task automatic drain();
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CoordW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input logic [CoordW-1:0] w, input logic [CoordW-1:0] h);
		drain();
		write_reg(RegWidth, w);
		write_reg(RegHeight, h);
	endtask

	// Mostly well-formed text with random content, plus noise and broken GBK pairs
	task automatic random_string();
		int         len, pick, top, w;
		logic [CoordW-1:0] sx, sy;
		w   = int'(sb.width_reg);
		top = int'(sb.height_reg) - int'(BottomMargin);
		pick = $urandom_range(0, 9);
		if (pick < 7)
			sx = CoordW'($urandom_range(0, w));
		else if (pick < 9)
			sx = CoordW'((w > 16) ? w - int'($urandom_range(0, 16)) : w);
		else
			sx = CoordW'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 8)
			sy = CoordW'($urandom_range(top + 1, int'(CoordMax)));
		else if (pick < 28)
			sy = CoordW'(top - int'($urandom_range(0, (top < 48) ? top : 48)));
		else
			sy = CoordW'($urandom_range(0, top));
		start_string(sx, sy);
		len = $urandom_range(1, 40);
		for (int k = 0; k < len; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				offer(8'($urandom_range(8'h20, 8'h7e)));
			end else if (pick < 70) begin
				offer(8'($urandom_range(GbkLeadBase, 8'hff)));
				if ($urandom_range(0, 1))
					offer(8'($urandom_range(TrailLow, ByteDel - 8'd1)));
				else
					offer(8'($urandom_range(ByteHiBase, TrailHigh)));
			end else if (pick < 77) begin
				offer(ByteLf);
			end else if (pick < 83) begin
				offer(ByteCr);
			end else if (pick < 90) begin
				offer(8'($urandom));
			end else if (pick < 96) begin
				offer(8'($urandom_range(GbkLeadBase, 8'hff)));
				case ($urandom_range(0, 2))
					0: offer(8'($urandom_range(0, TrailLow - 8'd1)));
					1: offer(ByteDel);
					default: offer(TrailHigh + 8'd1);
				endcase
			end else begin
				// lead left hanging; the next string start drops it
				offer(8'($urandom_range(GbkLeadBase, 8'hff)));
				break;
			end
		end
	endtask

	initial begin : stimulus
		int target;
		bit hold_done;
		arst_n  = 1'b0;
		push    = 1'b0;
		item    = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset screen size 480x272
		start_string(12'd0, 12'd0);
		offer(8'h41);
		offer(ByteDel);
		offer(ByteNul);
		offer(ByteHiBase);
		offer(ByteLf);
		offer(ByteCr);
		offer(GbkLeadBase);
		offer(TrailLow);
		offer(8'hff);
		offer(TrailHigh);
		offer(8'hb0);
		offer(ByteHiBase);
		offer(8'hc1);
		offer(ByteDel - 8'd1);
		offer(8'hd0);
		offer(ByteDel);
		offer(8'hd0);
		offer(TrailLow - 8'd1);
		offer(8'hd0);
		offer(TrailHigh + 8'd1);
		// lead dropped by a new string on the last row that still fits, then a wrap
		offer(8'he0);
		start_string(12'd478, 12'd262);
		offer(8'h57);
		offer(8'h58);
		// one row lower: whole string suppressed
		start_string(12'd0, 12'd263);
		offer(8'h5a);

		for (int p = 0; p < PhaseCount; p++) begin
			case (p)
				0: ;
				1: configure(12'd1, 12'd16);
				2: configure(CoordMax, CoordMax);
				3: configure(CoordMax, 12'd16);
				4: configure(12'd1, CoordMax);
				default: configure(CoordW'($urandom_range(1, 4095)),
					CoordW'($urandom_range(16, 4095)));
			endcase
			target    = counted + PhaseItems;
			hold_done = (p != 1 && p != 4);
			while (counted < target) begin
				if (!hold_done && counted >= target - PhaseItems / 2) begin
					// result side stops; keep pushing so the queues fill and full rises
					rx_hold_req = 1'b1;
					burst_left  = 80;
					hold_done   = 1'b1;
				end
				random_string();
			end
		end

		drain();
		if (sb.pending() != 0)
			sb.report($sformatf("%0d glyphs never arrived", sb.pending()));
		$display("Sent %0d requests (%0d more in suppressed strings) over %0d screen sizes.",
			counted, muted_reqs, PhaseCount);
		$display("Checked %0d ASCII and %0d GBK glyphs; %0d mismatches.",
			sb.ascii_glyphs, sb.gbk_glyphs, sb.errors);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
